// ----- design/psfi_pkg.sv -----
// ----------------------------------------------------------------------------
// psfi_pkg
// Shared widths, constants and command codes of the speed factor interpolator.
// ----------------------------------------------------------------------------
package psfi_pkg;

  localparam int NumJointsDef    = 6;
  localparam int MaxWaypointsDef = 64;

  localparam int PosW    = 16;
  localparam int FactorW = 16;
  localparam int TimeW   = 32;
  localparam int SegW    = 6;
  localparam int DilW    = 48;
  localparam int SqW     = 36;
  localparam int DistW   = 18;

  localparam logic [15:0] MinFactorRst = 16'd24576;
  localparam logic [16:0] OneQ15       = 17'd32768;

  localparam logic CmdLoad  = 1'b0;
  localparam logic CmdQuery = 1'b1;

  // tdata of the input channel, highest bits first
  typedef struct packed {
    logic [TimeW-1:0]   query_time;
    logic [FactorW-1:0] waypoint_factor;
    logic [PosW-1:0]    joint_pos_5;
    logic [PosW-1:0]    joint_pos_4;
    logic [PosW-1:0]    joint_pos_3;
    logic [PosW-1:0]    joint_pos_2;
    logic [PosW-1:0]    joint_pos_1;
    logic [PosW-1:0]    joint_pos_0;
  } in_data_t;

  // start strobe and radicand of the start/done handshake to the root unit
  typedef struct packed {
    logic            start;
    logic [SqW-1:0]  value;
  } sqrt_req_t;

endpackage

// ----- design/psfi_sqrt.sv -----
// ----------------------------------------------------------------------------
// psfi_sqrt
// Iterative integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module psfi_sqrt (
  input  logic                           clk,
  input  logic                           rst_n,
  input  psfi_pkg::sqrt_req_t            req,
  output logic                           done,
  output logic [psfi_pkg::DistW-1:0]     root
);
  localparam int SqW   = psfi_pkg::SqW;
  localparam int DistW = psfi_pkg::DistW;

  logic [SqW-1:0]   rem_r, rem_nxt;
  logic [DistW-1:0] res_r, res_nxt;
  logic [4:0]       cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt, done_r, done_nxt;
  logic [SqW+1:0]   trial;
  logic [SqW+1:0]   rem_sh;

  // restoring square root: try each root bit from the top, res held in place
  always_comb begin
    rem_nxt  = rem_r;
    res_nxt  = res_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    rem_sh   = '0;
    trial    = '0;
    if (req.start) begin
      rem_nxt  = req.value;
      res_nxt  = '0;
      cnt_nxt  = 5'(DistW - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_sh = {2'b00, rem_r};
      trial  = ((SqW+2)'(res_r) << (cnt_r + 5'd1)) | ((SqW+2)'(1) << {cnt_r, 1'b0});
      if (rem_sh >= trial) begin
        rem_nxt = SqW'(rem_sh - trial);
        res_nxt = res_r | (DistW'(1) << cnt_r);
      end
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt;
    res_r <= res_nxt;
    cnt_r <= cnt_nxt;
  end

  assign done = done_r;
  assign root = res_r;
endmodule

// ----- design/psfi_div.sv -----
// ----------------------------------------------------------------------------
// psfi_div
// Iterative unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module psfi_div #(
  parameter int NumW = 36,
  parameter int DenW = 19
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [NumW-1:0] num,
  input  logic [DenW-1:0] den,
  output logic            done,
  output logic [NumW-1:0] quot
);
  localparam int CntW = $clog2(NumW + 1);

  logic [NumW-1:0] q_r, q_nxt;
  logic [DenW:0]   rem_r, rem_nxt;
  logic [DenW-1:0] den_r, den_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            busy_r, busy_nxt, done_r, done_nxt;
  logic [DenW:0]   sh;

  // shift-subtract long division
  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    sh       = {rem_r[DenW-1:0], q_r[NumW-1]};
    if (start) begin
      q_nxt    = num;
      rem_nxt  = '0;
      den_nxt  = den;
      cnt_nxt  = CntW'(NumW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (sh >= {1'b0, den_r}) begin
        rem_nxt = sh - {1'b0, den_r};
        q_nxt   = {q_r[NumW-2:0], 1'b1};
      end else begin
        rem_nxt = sh;
        q_nxt   = {q_r[NumW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CntW'(1);
      if (cnt_r == CntW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    cnt_r <= cnt_nxt;
  end

  assign done = done_r;
  assign quot = q_r;
endmodule

// ----- design/path_speed_factor_interpolator_top.sv -----
// ----------------------------------------------------------------------------
// path_speed_factor_interpolator_top
// Interpolates a speed factor along a stored waypoint path and dilates time.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : items; in_tuser[0] = cmd (0 load, 1 query), in_tuser[1] = start_path.
//           in_tdata carries the joint positions, waypoint factor and query time.
//   out_* : one result item per query, none per load.
//   cfg_* : writes the lower factor clamp (Q1.15); write only while idle.
// Sequence:
//   a load is taken in the idle state and written in the load state; all
//   joints of one waypoint form one memory word.
//   a query reads 2 to 4 waypoints, runs two square roots on one shared
//   unit, the divider and the dilation step, then loads the output register;
//   a new item is taken only once the sequencer is back in idle. A zero
//   distance sum skips the divider; a path shorter than two waypoints reads
//   its one waypoint, if any, and goes straight to the dilation step.
// Reset: path, segment, previous time and dilation term clear; the
//   waypoint memories are not cleared and need no clearing pass.
// Stall: the result sits in the output register; the next item is taken and
//   worked on meanwhile, and its last cycle waits until the old one is taken.
// ----------------------------------------------------------------------------
module path_speed_factor_interpolator_top #(
  parameter int NUM_JOINTS    = psfi_pkg::NumJointsDef,
  parameter int MAX_WAYPOINTS = psfi_pkg::MaxWaypointsDef
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // joint_pos_0..5, waypoint_factor, query_time
  input  logic [143:0] in_tdata,
  // cmd, start_path
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // interp_factor, adjusted_time, segment_index
  output logic [55:0]  out_tdata,
  // degenerate
  output logic         out_tuser,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [15:0]  cfg_data
);
  localparam int PosW  = psfi_pkg::PosW;
  localparam int SqW   = psfi_pkg::SqW;
  localparam int DistW = psfi_pkg::DistW;
  localparam int DilW  = psfi_pkg::DilW;
  localparam int SegW  = psfi_pkg::SegW;
  localparam int AW    = $clog2(MAX_WAYPOINTS);
  localparam int CW    = $clog2(MAX_WAYPOINTS + 1);

  localparam logic [3:0] StIdle = 4'd0, StRd = 4'd1, StAcc = 4'd2, StRoot = 4'd3,
                         StRootW = 4'd4, StDiv = 4'd5, StDivW = 4'd6, StDil = 4'd7,
                         StLoad = 4'd8;

  // memories: one word per waypoint holds all joints
  logic [NUM_JOINTS*PosW-1:0] wp_mem [MAX_WAYPOINTS];
  logic [15:0]                fac_mem [MAX_WAYPOINTS];
  logic [NUM_JOINTS*PosW-1:0] wp_rd_r;
  logic [15:0]                fac_rd_r;
  logic [AW-1:0]              rd_addr;
  logic                       wr_en;

  logic [3:0]  st_r, st_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [AW-1:0] seg_r, seg_nxt;
  logic [31:0] prev_r, prev_nxt;
  logic [DilW-1:0] dil_r, dil_nxt;
  logic [15:0] minf_r;
  psfi_pkg::in_data_t item_r;
  logic        start_r;
  logic [1:0]  k_r, k_nxt;
  logic [SqW-1:0] sq_r [3];
  logic [SqW-1:0] sq_nxt [3];
  logic [DistW-1:0] d_r [2];
  logic [DistW-1:0] d_nxt [2];
  logic [15:0] f_r [2];
  logic [15:0] f_nxt [2];
  logic        has2_r, has2_nxt, degen_r, degen_nxt;
  logic [15:0] interp_r, interp_nxt;
  logic [55:0] odata_r, odata_nxt;
  logic        oval_r, oval_nxt, ouser_r, ouser_nxt;
  logic [SqW-1:0] sqsum;
  logic        rt_start, rt_done;
  logic [DistW-1:0] rt_root;
  psfi_pkg::sqrt_req_t rt_req;
  logic        dv_start, dv_done;
  logic [SqW-1:0] dv_num, dv_quot;
  logic [DistW:0] dsum;
  logic signed [17:0] delta;
  logic signed [33:0] dt;
  logic signed [DilW-1:0] dnew;
  logic signed [DilW:0] rnd, qt;
  logic signed [DilW:0] adj;
  logic [15:0] sf;
  logic [PosW-1:0] jin [6];

  assign jin[0] = item_r.joint_pos_0; assign jin[1] = item_r.joint_pos_1;
  assign jin[2] = item_r.joint_pos_2; assign jin[3] = item_r.joint_pos_3;
  assign jin[4] = item_r.joint_pos_4; assign jin[5] = item_r.joint_pos_5;

  // squared distance of read word to the held point
  always_comb begin
    logic signed [PosW:0] df;
    logic signed [2*PosW+1:0] pr;
    sqsum = '0;
    for (int j = 0; j < NUM_JOINTS; j++) begin
      df = $signed({wp_rd_r[j*PosW+PosW-1], wp_rd_r[j*PosW +: PosW]}) -
           $signed({jin[j][PosW-1], jin[j]});
      pr = df * df;
      sqsum = sqsum + SqW'(pr);
    end
  end

  // memory ports
  assign wr_en = (st_r == StLoad) && (start_r || cnt_r < CW'(MAX_WAYPOINTS));
  always_ff @(posedge clk) begin
    if (wr_en) begin
      wp_mem[start_r ? '0 : cnt_r[AW-1:0]] <= item_r[NUM_JOINTS*PosW-1:0];
      fac_mem[start_r ? '0 : cnt_r[AW-1:0]] <= item_r.waypoint_factor;
    end
    wp_rd_r  <= wp_mem[rd_addr];
    fac_rd_r <= fac_mem[rd_addr];
  end
  assign rd_addr = AW'(seg_r + AW'(k_r));

  assign dsum   = {1'b0, d_r[0]} + {1'b0, d_r[1]};
  assign dv_num = SqW'(f_r[0] * d_r[1]) + SqW'(f_r[1] * d_r[0]) + SqW'(dsum >> 1);
  assign rt_req = '{start: rt_start, value: k_r[0] ? sq_r[1] : sq_r[0]};

  psfi_sqrt u_sqrt (.clk, .rst_n, .req(rt_req), .done(rt_done), .root(rt_root));
  psfi_div #(.NumW(SqW), .DenW(DistW+1)) u_div (.clk, .rst_n, .start(dv_start),
    .num(dv_num), .den(dsum), .done(dv_done), .quot(dv_quot));

  assign sf    = (interp_r > minf_r) ? interp_r : minf_r;
  assign delta = $signed({2'b00, sf}) - $signed({1'b0, psfi_pkg::OneQ15});
  assign dt    = $signed({2'b00, item_r.query_time}) - $signed({2'b00, prev_r});
  assign dnew  = $signed(dil_r + DilW'(delta * dt));
  assign rnd   = $signed({dnew[DilW-1], dnew}) + (DilW+1)'(16384);
  assign qt    = rnd >>> 15;
  assign adj   = $signed({{(DilW-32){1'b0}}, 1'b0, item_r.query_time}) + qt;

  // control sequencer
  always_comb begin
    st_nxt = st_r; cnt_nxt = cnt_r; seg_nxt = seg_r; prev_nxt = prev_r;
    dil_nxt = dil_r; k_nxt = k_r; sq_nxt = sq_r; d_nxt = d_r; f_nxt = f_r;
    has2_nxt = has2_r; degen_nxt = degen_r; interp_nxt = interp_r;
    odata_nxt = odata_r; oval_nxt = oval_r; ouser_nxt = ouser_r;
    rt_start = 1'b0; dv_start = 1'b0;
    if (out_tready) oval_nxt = 1'b0;
    unique case (st_r)
      StIdle: begin
        if (in_tvalid) begin
          if (in_tuser[0] == psfi_pkg::CmdLoad) begin
            st_nxt = StLoad;
          end else if (cnt_r < CW'(2)) begin
            seg_nxt = '0; degen_nxt = 1'b1; k_nxt = '0;
            interp_nxt = '0;
            st_nxt = (cnt_r == CW'(1)) ? StRd : StDil;
          end else begin
            degen_nxt = 1'b0; k_nxt = '0;
            has2_nxt = (CW'(seg_r) + CW'(2)) < cnt_r;
            st_nxt = StRd;
          end
        end
      end
      StLoad: begin
        if (start_r) begin
          cnt_nxt = CW'(1); seg_nxt = '0; prev_nxt = '0; dil_nxt = '0;
        end else if (cnt_r < CW'(MAX_WAYPOINTS)) begin
          cnt_nxt = cnt_r + CW'(1);
        end
        st_nxt = StIdle;
      end
      StRd: st_nxt = StAcc;
      StAcc: begin
        if (degen_r) begin
          interp_nxt = fac_rd_r; st_nxt = StDil;
        end else begin
          sq_nxt[k_r] = sqsum;
          if (k_r < 2'd2) f_nxt[k_r[0]] = fac_rd_r;
          if (k_r == 2'd0 || (k_r == 2'd1 && has2_r)) begin
            k_nxt = k_r + 2'd1; st_nxt = StRd;
          end else if (k_r == 2'd2 && sqsum <= sq_r[0]) begin
            // advance: reload factors from the new pair
            seg_nxt = seg_r + AW'(1);
            sq_nxt[0] = sq_r[1]; sq_nxt[1] = sqsum;
            f_nxt[0] = f_r[1]; has2_nxt = 1'b0;
            k_nxt = 2'd1; st_nxt = StRd;
          end else begin
            k_nxt = '0; st_nxt = StRoot;
          end
        end
      end
      StRoot: begin
        rt_start = 1'b1; st_nxt = StRootW;
      end
      StRootW: begin
        if (rt_done) begin
          d_nxt[k_r[0]] = rt_root;
          if (k_r == 2'd0) begin
            k_nxt = 2'd1; st_nxt = StRoot;
          end else begin
            st_nxt = StDiv;
          end
        end
      end
      StDiv: begin
        if (dsum == '0) begin
          interp_nxt = f_r[0]; degen_nxt = 1'b1; st_nxt = StDil;
        end else begin
          dv_start = 1'b1; st_nxt = StDivW;
        end
      end
      StDivW: begin
        if (dv_done) begin
          interp_nxt = (dv_quot > SqW'(16'hFFFF)) ? 16'hFFFF : dv_quot[15:0];
          st_nxt = StDil;
        end
      end
      // update state and load the output register once it is free
      StDil: begin
        if (!oval_r || out_tready) begin
          dil_nxt = dnew; prev_nxt = item_r.query_time;
          odata_nxt[15:0] = interp_r;
          odata_nxt[47:16] = adj[DilW] ? 32'd0 : ((|adj[DilW-1:32]) ? 32'hFFFF_FFFF
                                                                    : adj[31:0]);
          odata_nxt[55:48] = {2'b00, SegW'(seg_r)};
          ouser_nxt = degen_r;
          oval_nxt = 1'b1; st_nxt = StIdle;
        end
      end
      default: st_nxt = StIdle;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= StIdle; cnt_r <= '0; seg_r <= '0; prev_r <= '0; dil_r <= '0;
      oval_r <= 1'b0; minf_r <= psfi_pkg::MinFactorRst;
    end else begin
      st_r <= st_nxt; cnt_r <= cnt_nxt; seg_r <= seg_nxt; prev_r <= prev_nxt;
      dil_r <= dil_nxt; oval_r <= oval_nxt;
      if (cfg_valid) minf_r <= cfg_data;
    end
    if (st_r == StIdle && in_tvalid) begin
      item_r <= in_tdata; start_r <= in_tuser[1];
    end
    k_r <= k_nxt; sq_r <= sq_nxt; d_r <= d_nxt; f_r <= f_nxt; has2_r <= has2_nxt;
    degen_r <= degen_nxt; interp_r <= interp_nxt; odata_r <= odata_nxt;
    ouser_r <= ouser_nxt;
  end

  assign in_tready  = (st_r == StIdle);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = oval_r;
  assign out_tdata  = odata_r;
  assign out_tuser  = ouser_r;
endmodule

// ----- tb/psfi_checker.sv -----
// ----------------------------------------------------------------------------
// psfi_checker
// Watches the item, result and register channels of the speed factor
// interpolator, predicts every query result from its own copy of the path
// and dilation state, and compares the results field by field in order.
// ----------------------------------------------------------------------------
module psfi_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  // joint_pos_0..5, waypoint_factor, query_time
  input  logic [143:0] in_tdata,
  // cmd, start_path
  input  logic [1:0]   in_tuser,
  input  logic         out_tvalid,
  input  logic         out_tready,
  // interp_factor, adjusted_time, segment_index
  input  logic [55:0]  out_tdata,
  // degenerate
  input  logic         out_tuser,
  input  logic         cfg_valid,
  input  logic         cfg_ready,
  input  logic [15:0]  cfg_data,
  output int           err_count,
  output int           pending
);
  localparam int NJ = psfi_pkg::NumJointsDef;
  localparam int NW = psfi_pkg::MaxWaypointsDef;
  localparam int QDepth = 16;

  typedef struct packed {
    logic [15:0] factor;
    logic [31:0] adj_time;
    logic [5:0]  seg;
    logic        degen;
  } speed_result_t;

  // model copy of the path and dilation state
  logic [15:0]   path_pos [NW][NJ];
  logic [15:0]   path_factor [NW];
  int            path_len;
  int            seg_ptr;
  logic [31:0]   last_time;
  logic [47:0]   dilation;
  logic [15:0]   min_factor;
  speed_result_t due_q [QDepth];
  int            wr_cnt;
  int            rd_cnt;

  assign pending = wr_cnt - rd_cnt;

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic longint unsigned sq_distance(input int wp, input logic [143:0] d);
    longint unsigned acc;
    longint df;
    acc = 0;
    for (int j = 0; j < NJ; j++) begin
      df = longint'($signed(path_pos[wp][j])) - longint'($signed(d[16*j +: 16]));
      acc += longint'(df * df);
    end
    return acc;
  endfunction

  // mix the factors of the current segment and update the time dilation
  task automatic predict_query(input logic [143:0] d, output speed_result_t r);
    longint unsigned s0, s1, s2, d0, d1, sum, num;
    longint interp, sf, dt, dil, q, adj;
    logic [31:0] t;
    int s;
    t = d[143:112];
    r.degen = 1'b0;
    if (path_len < 2) begin
      interp = (path_len == 1) ? longint'(path_factor[0]) : 0;
      seg_ptr = 0;
      r.degen = 1'b1;
    end else begin
      s = seg_ptr;
      s0 = sq_distance(s, d);
      s1 = sq_distance(s + 1, d);
      if (s + 2 < path_len) begin
        s2 = sq_distance(s + 2, d);
        if (s2 <= s0) begin
          s++;
          s0 = s1;
          s1 = s2;
        end
      end
      seg_ptr = s;
      d0 = int_sqrt(s0);
      d1 = int_sqrt(s1);
      sum = d0 + d1;
      if (sum == 0) begin
        interp = longint'(path_factor[s]);
        r.degen = 1'b1;
      end else begin
        num = longint'(path_factor[s]) * d1 + longint'(path_factor[s + 1]) * d0;
        interp = longint'((num + sum / 2) / sum);
        if (interp > 65535) interp = 65535;
      end
    end
    sf = (interp > longint'(min_factor)) ? interp : longint'(min_factor);
    dt = longint'(t) - longint'(last_time);
    dilation = dilation + 48'((sf - 32768) * dt);
    last_time = t;
    dil = longint'($signed(dilation));
    // floor of (term + half) / 2^15 gives round half up
    q = (dil + 16384) >>> 15;
    adj = longint'(t) + q;
    if (adj < 0) adj = 0;
    if (adj > 64'hFFFF_FFFF) adj = 64'hFFFF_FFFF;
    r.factor = interp[15:0];
    r.adj_time = adj[31:0];
    r.seg = 6'(seg_ptr);
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    err_count++;
  endtask

  // track items, register writes and results
  always @(posedge clk) begin
    speed_result_t r, want;
    if (!rst_n) begin
      path_len = 0;
      seg_ptr = 0;
      last_time = '0;
      dilation = '0;
      min_factor = psfi_pkg::MinFactorRst;
      wr_cnt = 0;
      rd_cnt = 0;
    end else begin
      if (cfg_valid && cfg_ready) min_factor = cfg_data;
      if (in_tvalid && in_tready) begin
        if (in_tuser[0] == psfi_pkg::CmdLoad) begin
          if (in_tuser[1]) begin
            path_len = 0;
            seg_ptr = 0;
            last_time = '0;
            dilation = '0;
          end
          if (path_len < NW) begin
            for (int j = 0; j < NJ; j++) path_pos[path_len][j] = in_tdata[16*j +: 16];
            path_factor[path_len] = in_tdata[111:96];
            path_len++;
          end
        end else begin
          predict_query(in_tdata, r);
          due_q[wr_cnt % QDepth] = r;
          wr_cnt++;
        end
      end
      if (out_tvalid && out_tready) begin
        if (wr_cnt == rd_cnt) begin
          report_mismatch("unexpected result item", 1, 0);
        end else begin
          want = due_q[rd_cnt % QDepth];
          rd_cnt++;
          if (out_tdata[15:0] !== want.factor)
            report_mismatch("interp_factor", out_tdata[15:0], want.factor);
          if (out_tdata[47:16] !== want.adj_time)
            report_mismatch("adjusted_time", out_tdata[47:16], want.adj_time);
          if (out_tdata[53:48] !== want.seg)
            report_mismatch("segment_index", out_tdata[53:48], want.seg);
          if (out_tuser !== want.degen)
            report_mismatch("degenerate", out_tuser, want.degen);
        end
      end
    end
  end

endmodule

// ----- tb/tb_path_speed_factor_interpolator_top.sv -----
// ----------------------------------------------------------------------------
// tb_path_speed_factor_interpolator_top
// Stimulus for the speed factor interpolator: directed corner items, then
// random paths with queries walking along them, under several clamp
// settings and random stalls on both sides. The checker gives the verdict.
// ----------------------------------------------------------------------------
module tb_path_speed_factor_interpolator_top;

  localparam int CycleLimit = 1000000;
  localparam int DrainCycles = 200;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [143:0] in_tdata;
  logic [1:0]   in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [55:0]  out_tdata;
  logic         out_tuser;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [15:0]  cfg_data;
  int           err_count;
  int           pending;
  logic         steady;
  int           cycles = 0;
  int           item_total;

  // path copy used to place queries near the loaded waypoints
  logic signed [15:0] route [64][6];
  int                 route_len;
  logic [31:0]        clock_us;

  path_speed_factor_interpolator_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  psfi_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .err_count(err_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic int idle_draw();
    return steady ? 0 : $urandom_range(0, 4);
  endfunction

  // result side stalls
  initial begin
    int w;
    out_tready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      w = idle_draw();
      if (w > 0) begin
        out_tready <= 1'b0;
        repeat (w) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk iff out_tvalid);
    end
  end

  task automatic send_item(input logic cmd, input logic start, input logic [15:0] pos [6],
                           input logic [15:0] factor, input logic [31:0] t);
    int w;
    logic [143:0] d;
    d = '0;
    for (int j = 0; j < 6; j++) d[16*j +: 16] = pos[j];
    d[111:96] = factor;
    d[143:112] = t;
    w = idle_draw();
    if (w > 0) begin
      in_tvalid <= 1'b0;
      repeat (w) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= d;
    in_tuser <= {start, cmd};
    @(posedge clk iff in_tready);
    item_total++;
  endtask

  task automatic load_point(input logic start, input logic [15:0] pos [6],
                            input logic [15:0] factor);
    send_item(psfi_pkg::CmdLoad, start, pos, factor, $urandom);
  endtask

  task automatic query_point(input logic [15:0] pos [6], input logic [31:0] t);
    send_item(psfi_pkg::CmdQuery, 1'($urandom_range(0, 1)), pos, 16'($urandom), t);
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_min_factor(input logic [15:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk iff cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [15:0] rand_factor();
    case ($urandom_range(0, 5))
      0: return 16'd0;
      1: return 16'd32768;
      default: return 16'($urandom_range(0, 32768));
    endcase
  endfunction

  // one path of waypoints followed by queries walking along it
  task automatic run_route(input int nwp, input int nq);
    logic [15:0] p [6];
    int k, f, step;
    longint v;
    for (int i = 0; i < nwp; i++) begin
      for (int j = 0; j < 6; j++) begin
        if (i == 0) v = $signed(16'($urandom));
        else v = longint'(route[(i - 1) % 64][j]) + $signed(13'($urandom));
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        p[j] = v[15:0];
        if (i < 64) route[i][j] = v[15:0];
      end
      load_point(i == 0, p, rand_factor());
    end
    route_len = (nwp > 64) ? 64 : nwp;
    clock_us = ($urandom_range(0, 7) == 0) ? 32'hFFF0_0000 + $urandom_range(0, 99999)
                                           : $urandom_range(0, 1000);
    k = 0;
    f = 0;
    for (int n = 0; n < nq; n++) begin
      for (int j = 0; j < 6; j++) begin
        if ($urandom_range(0, 9) == 0 || route_len < 2) begin
          p[j] = 16'($urandom);
        end else begin
          v = longint'(route[k][j]) +
              (longint'(route[k + 1][j]) - longint'(route[k][j])) * f / 16 +
              $signed(7'($urandom));
          if (v > 32767) v = 32767;
          if (v < -32768) v = -32768;
          p[j] = v[15:0];
        end
      end
      case ($urandom_range(0, 19))
        0: clock_us = $urandom;
        1: clock_us = clock_us - $urandom_range(0, 50000);
        default: clock_us = clock_us + $urandom_range(0, 200000);
      endcase
      query_point(p, clock_us);
      step = $urandom_range(1, 6);
      f += step;
      while (f >= 16) begin
        f -= 16;
        if (k + 2 < route_len) k++;
      end
    end
  endtask

  initial begin
    logic [15:0] p [6];
    logic [15:0] settings [6];
    int target;
    steady = 1'b0;
    item_total = 0;
    route_len = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty path, single waypoint, zero distance, extremes, time backwards
    write_min_factor(psfi_pkg::MinFactorRst);
    for (int j = 0; j < 6; j++) p[j] = 16'h0000;
    query_point(p, 32'd1000);
    for (int j = 0; j < 6; j++) p[j] = 16'h8000;
    load_point(1'b1, p, 16'd32768);
    query_point(p, 32'hFFFF_FFFF);
    query_point(p, 32'd0);
    load_point(1'b0, p, 16'd0);
    query_point(p, 32'd5000);
    for (int j = 0; j < 6; j++) p[j] = 16'h7FFF;
    load_point(1'b0, p, 16'd16384);
    query_point(p, 32'd900000);
    for (int j = 0; j < 6; j++) p[j] = 16'h0000;
    query_point(p, 32'd100);
    load_point(1'b1, p, 16'd0);
    for (int j = 0; j < 6; j++) p[j] = 16'h7FFF;
    load_point(1'b0, p, 16'd32768);
    query_point(p, 32'hFFFF_0000);
    for (int j = 0; j < 6; j++) p[j] = 16'h4000;
    query_point(p, 32'hFFFF_FFFF);
    query_point(p, 32'd0);
    query_point(p, 32'hFFFF_FFFF);
    wait_idle();

    // random paths under several clamp settings
    settings[0] = 16'd0;
    settings[1] = 16'd32768;
    settings[2] = 16'($urandom_range(0, 32768));
    settings[3] = 16'd16384;
    settings[4] = 16'($urandom_range(0, 32768));
    settings[5] = psfi_pkg::MinFactorRst;
    for (int ph = 0; ph < 6; ph++) begin
      write_min_factor(settings[ph]);
      target = item_total + 105;
      steady = (ph == 3);
      if (ph == 2) run_route(66, 20);
      while (item_total < target)
        run_route(($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 8),
                  $urandom_range(4, 16));
      wait_idle();
    end

    if (err_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
